>>> hdl/char_lcd_4bit_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Character LCD sequencer assertion macros
// Concurrent assertion shorthands, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_4BIT_SEQUENCER_MACROS_SVH
`define CHAR_LCD_4BIT_SEQUENCER_MACROS_SVH

// consequent checked in the same cycle
`define CLCD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD sequencer package
// Shared types, constants and lookup tables.
// ----------------------------------------------------------------------------
package clcd_pkg;

	localparam int unsigned CFG_W           = 8;
	localparam int unsigned HOLD_W          = 10;
	localparam int unsigned IDX_W           = 5;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [7:0] ROW_MAX       = 8'd3;
	localparam logic [7:0] COL_MAX       = 8'd19;

	localparam logic [IDX_W-1:0] INIT_FIRST_CMD_IDX = 5'd7;
	localparam logic [IDX_W-1:0] INIT_LAST_IDX      = 5'd22;
	localparam logic [HOLD_W-1:0] INIT_FINAL_EXTRA  = 10'd2;

	localparam logic [CFG_W-1:0] PWR_UP_RST = 8'd50;
	localparam logic [CFG_W-1:0] PULSE_RST  = 8'd1;
	localparam logic [CFG_W-1:0] SETTLE_RST = 8'd2;

	typedef enum logic [1:0] {
		KIND_INIT   = 2'd0,
		KIND_CMD    = 2'd1,
		KIND_DATA   = 2'd2,
		KIND_CURSOR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_POWER_UP = 2'd0,
		CFG_PULSE    = 2'd1,
		CFG_SETTLE   = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		JOB_INIT = 2'd0,
		JOB_CMD  = 2'd1,
		JOB_DATA = 2'd2
	} job_kind_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_RUN  = 1'b1
	} back_state_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] value;
	} job_t;

	typedef struct packed {
		logic [CFG_W-1:0] power_up;
		logic [CFG_W-1:0] pulse;
		logic [CFG_W-1:0] settle;
	} cfg_t;

	typedef struct packed {
		logic              rs;
		logic [3:0]        nibble;
		logic              enable;
		logic [HOLD_W-1:0] hold;
	} phase_t;

	function automatic logic [6:0] row_base(input logic [1:0] r);
		logic [6:0] b;
		unique case (r)
			2'd0: b = 7'h00;
			2'd1: b = 7'h40;
			2'd2: b = 7'h14;
			2'd3: b = 7'h54;
			default: b = 7'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] init_cmd(input logic [1:0] i);
		logic [7:0] c;
		unique case (i)
			2'd0: c = 8'h28;
			2'd1: c = 8'h0C;
			2'd2: c = 8'h06;
			2'd3: c = 8'h01;
			default: c = 8'h01;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] init_nibble(input logic [1:0] i);
		return (i == 2'd2) ? 4'h2 : 4'h3;
	endfunction

	function automatic logic [HOLD_W-1:0] init_extra(input logic [1:0] i);
		logic [HOLD_W-1:0] e;
		unique case (i)
			2'd0: e = 10'd5;
			2'd1: e = 10'd1;
			default: e = 10'd0;
		endcase
		return e;
	endfunction

endpackage

>>> hdl/clcd_front.sv
// ----------------------------------------------------------------------------
// Character LCD sequencer front end
// Takes input transfers and turns each into a job for the back end.
// ----------------------------------------------------------------------------
module clcd_front import clcd_pkg::*; (
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] kind,
	input  logic [7:0] byte_value,
	input  logic [7:0] row,
	input  logic [7:0] column,
	output logic       push_valid,
	input  logic       push_ready,
	output job_t       push_job
);

	logic [1:0] row_c;
	logic [4:0] col_c;
	logic [6:0] addr;

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	always_comb begin
		row_c = (row > ROW_MAX) ? ROW_MAX[1:0] : row[1:0];
		col_c = (column > COL_MAX) ? COL_MAX[4:0] : column[4:0];
		addr  = 7'(col_c) + row_base(row_c);
		unique case (kind_t'(kind))
			KIND_INIT: begin
				push_job.kind  = JOB_INIT;
				push_job.value = byte_value;
			end
			KIND_CMD: begin
				push_job.kind  = JOB_CMD;
				push_job.value = byte_value;
			end
			KIND_DATA: begin
				push_job.kind  = JOB_DATA;
				push_job.value = byte_value;
			end
			KIND_CURSOR: begin
				push_job.kind  = JOB_CMD;
				push_job.value = CMD_SET_DDRAM | {1'b0, addr};
			end
			default: begin
				push_job.kind  = JOB_DATA;
				push_job.value = byte_value;
			end
		endcase
	end

endmodule

>>> hdl/clcd_queue.sv
// ----------------------------------------------------------------------------
// Character LCD sequencer job queue
// Small FIFO of classified jobs between front and back end.
// ----------------------------------------------------------------------------
module clcd_queue import clcd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_FULL;
	assign pop_valid  = count_q != '0;
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/clcd_back.sv
// ----------------------------------------------------------------------------
// Character LCD sequencer back end
// Steps through the pin phases of a job, one phase per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module clcd_back import clcd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   pop_valid,
	output logic   pop_ready,
	input  job_t   pop_job,
	output logic   m_valid,
	input  logic   m_ready,
	output phase_t m_phase,
	output logic   m_last
);

	back_state_t      state_q;
	back_state_t      state_d;
	job_t             job_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	phase_t           out_phase_q;
	logic             out_last_q;

	logic             advance;
	logic             load;
	logic             step;
	phase_t           cur;
	logic             cur_last;
	logic [HOLD_W-1:0] extra;
	logic [2:0]       j;
	logic [IDX_W-1:0] k_full;
	logic [3:0]       k;
	logic [7:0]       b;

	assign advance = !out_valid_q || m_ready;
	assign m_valid = out_valid_q;
	assign m_phase = out_phase_q;
	assign m_last  = out_last_q;

	// phase decode
	always_comb begin
		j      = idx_q[2:0] - 3'd1;
		k_full = idx_q - INIT_FIRST_CMD_IDX;
		k      = k_full[3:0];
		b      = init_cmd(k[3:2]);
		extra  = '0;
		cur    = '0;
		cur_last = 1'b0;
		unique case (job_q.kind)
			JOB_INIT: begin
				if (idx_q == '0) begin
					cur.hold = HOLD_W'(cfg.power_up);
				end else if (idx_q < INIT_FIRST_CMD_IDX) begin
					cur.nibble = init_nibble(j[2:1]);
					cur.enable = !j[0];
					extra      = j[0] ? init_extra(j[2:1]) : '0;
					cur.hold   = HOLD_W'(cfg.pulse) + extra;
				end else begin
					cur.nibble = k[1] ? b[3:0] : b[7:4];
					cur.enable = !k[0];
					if (k[1:0] == 2'd3) begin
						extra = HOLD_W'(cfg.settle)
							+ ((k[3:2] == 2'd3) ? INIT_FINAL_EXTRA : '0);
					end
					cur.hold = HOLD_W'(cfg.pulse) + extra;
					cur_last = idx_q == INIT_LAST_IDX;
				end
			end
			JOB_CMD, JOB_DATA: begin
				cur.rs     = job_q.kind == JOB_DATA;
				cur.nibble = idx_q[1] ? job_q.value[3:0] : job_q.value[7:4];
				cur.enable = !idx_q[0];
				cur_last   = idx_q[1:0] == 2'd3;
				if (cur_last && job_q.kind == JOB_CMD) begin
					extra = HOLD_W'(cfg.settle);
				end
				cur.hold = HOLD_W'(cfg.pulse) + extra;
			end
			default: begin
				cur_last = 1'b1;
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		step      = 1'b0;
		pop_ready = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					pop_ready = 1'b1;
					load      = 1'b1;
					state_d   = BK_RUN;
				end
			end
			BK_RUN: begin
				if (advance) begin
					step = 1'b1;
					if (cur_last) begin
						if (pop_valid) begin
							pop_ready = 1'b1;
							load      = 1'b1;
						end else begin
							state_d = BK_IDLE;
						end
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				idx_q <= '0;
			end else if (step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= pop_job;
		end
		if (step) begin
			out_phase_q <= cur;
			out_last_q  <= cur_last;
		end
	end

endmodule

>>> hdl/char_lcd_4bit_sequencer.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit sequencer
// Turns init, command, data and set-cursor requests into timed pin phases
// for an HD44780-type display on a 4-bit bus.
// ----------------------------------------------------------------------------
// Each output transfer is one pin phase (RS, D7..D4, E, hold time in ms);
// tlast marks the final phase of a request. Command, data and set-cursor
// requests give 4 phases, init gives 23. The back-end phase sequencer emits
// one phase per cycle while m_tready is high; the first phase passes through
// the queue, the job register and the output register. A queue of QUEUE_DEPTH
// classified requests lets the input run ahead of the output. The user must
// write cfg_* timing registers only while idle; the block does not check it.
module char_lcd_4bit_sequencer import clcd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // byte_value[7:0], row[15:8], column[23:16]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // register_select[0], nibble[4:1], enable[5], hold_ms[15:6]
	output logic        m_tlast
);

	cfg_t   cfg_q;
	logic   push_valid;
	logic   push_ready;
	job_t   push_job;
	logic   pop_valid;
	logic   pop_ready;
	job_t   pop_job;
	phase_t phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_up <= PWR_UP_RST;
			cfg_q.pulse    <= PULSE_RST;
			cfg_q.settle   <= SETTLE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_POWER_UP: cfg_q.power_up <= cfg_data;
				CFG_PULSE:    cfg_q.pulse    <= cfg_data;
				CFG_SETTLE:   cfg_q.settle   <= cfg_data;
				default:      ;
			endcase
		end
	end

	clcd_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.kind       (s_tuser),
		.byte_value (s_tdata[7:0]),
		.row        (s_tdata[15:8]),
		.column     (s_tdata[23:16]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	clcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	clcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_phase   (phase),
		.m_last    (m_tlast)
	);

	assign m_tdata = {phase.hold, phase.enable, phase.nibble, phase.rs};

endmodule

>>> hdl/clcd_checker.sv
// ----------------------------------------------------------------------------
// Character LCD sequencer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_lcd_4bit_sequencer_macros.svh"

module clcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	`CLCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output transfer changed")
	`CLCD_ASSERT_SAME(a_high_not_last, m_tvalid && m_tdata[5], !m_tlast, "enable-high phase marked last")
	`CLCD_ASSERT_SAME(a_hold_max, m_tvalid, m_tdata[15:6] <= 10'd512, "hold time out of range")
	`CLCD_ASSERT_SAME(a_high_hold, m_tvalid && m_tdata[5], m_tdata[15:6] <= 10'd255, "enable-high hold exceeds pulse width")

endmodule

bind char_lcd_4bit_sequencer clcd_checker u_clcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

>>> verif/char_lcd_4bit_sequencer_tb_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD sequencer pin phase tracker
// Holds a copy of the timing registers and predicts the pin phases each
// request produces, then compares the phases the block sends against them.
// ----------------------------------------------------------------------------
package char_lcd_4bit_sequencer_tb_pkg;

	import clcd_pkg::*;

	localparam logic [7:0] INIT_FUNCTION_SET = 8'h28;
	localparam logic [7:0] INIT_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] INIT_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] INIT_CLEAR        = 8'h01;
	localparam logic [3:0] WAKE_NIBBLE       = 4'h3;
	localparam logic [3:0] FOUR_BIT_NIBBLE   = 4'h2;
	localparam logic [9:0] WAKE_EXTRA_FIRST  = 10'd5;
	localparam logic [9:0] WAKE_EXTRA_SECOND = 10'd1;
	localparam logic [9:0] CLEAR_EXTRA       = 10'd2;
	localparam int         REPORT_LIMIT      = 10;

	typedef struct packed {
		logic       rs;
		logic [3:0] nibble;
		logic       enable;
		logic [9:0] hold;
		logic       last;
	} pin_phase_t;

	class pin_phase_tracker;
		logic [7:0] power_up_ms;
		logic [7:0] phase_ms;
		logic [7:0] settle_ms;
		pin_phase_t pending_phases[$];
		int         mismatch_count;
		logic [6:0] ddram_row_start[4];

		function new();
			power_up_ms = PWR_UP_RST;
			phase_ms = PULSE_RST;
			settle_ms = SETTLE_RST;
			mismatch_count = 0;
			ddram_row_start = '{7'h00, 7'h40, 7'h14, 7'h54};
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] value);
			case (idx)
				CFG_POWER_UP: power_up_ms = value;
				CFG_PULSE:    phase_ms = value;
				CFG_SETTLE:   settle_ms = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_phases.size();
		endfunction

		function void push_phase(logic rs, logic [3:0] nib, logic en, logic [9:0] hold);
			pin_phase_t p;
			p.rs = rs;
			p.nibble = nib;
			p.enable = en;
			p.hold = hold;
			p.last = 1'b0;
			pending_phases.push_back(p);
		endfunction

		function void push_nibble(logic rs, logic [3:0] nib, logic [9:0] extra);
			push_phase(rs, nib, 1'b1, 10'(phase_ms));
			push_phase(rs, nib, 1'b0, 10'(phase_ms) + extra);
		endfunction

		function void push_byte(logic rs, logic [7:0] value, logic [9:0] extra);
			push_nibble(rs, value[7:4], '0);
			push_nibble(rs, value[3:0], extra);
		endfunction

		function void add_request(kind_t kind, logic [7:0] value, logic [7:0] row,
				logic [7:0] column);
			logic [1:0] r;
			logic [7:0] c;
			logic [7:0] addr;
			case (kind)
				KIND_INIT: begin
					push_phase(1'b0, 4'h0, 1'b0, 10'(power_up_ms));
					push_nibble(1'b0, WAKE_NIBBLE, WAKE_EXTRA_FIRST);
					push_nibble(1'b0, WAKE_NIBBLE, WAKE_EXTRA_SECOND);
					push_nibble(1'b0, FOUR_BIT_NIBBLE, '0);
					push_byte(1'b0, INIT_FUNCTION_SET, 10'(settle_ms));
					push_byte(1'b0, INIT_DISPLAY_ON, 10'(settle_ms));
					push_byte(1'b0, INIT_ENTRY_MODE, 10'(settle_ms));
					push_byte(1'b0, INIT_CLEAR, 10'(settle_ms) + CLEAR_EXTRA);
				end
				KIND_CMD:  push_byte(1'b0, value, 10'(settle_ms));
				KIND_DATA: push_byte(1'b1, value, '0);
				default: begin
					r = (row > ROW_MAX) ? 2'(ROW_MAX) : row[1:0];
					c = (column > COL_MAX) ? COL_MAX : column;
					addr = CMD_SET_DDRAM | {1'b0, 7'(c + 8'(ddram_row_start[r]))};
					push_byte(1'b0, addr, 10'(settle_ms));
				end
			endcase
			pending_phases[pending_phases.size() - 1].last = 1'b1;
		endfunction

		function void compare_phase(logic [15:0] data, logic last);
			pin_phase_t want;
			pin_phase_t got;
			got = {data[0], data[4:1], data[5], data[15:6], last};
			if (pending_phases.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("ERROR: unexpected phase rs=%0d nib=%h en=%0d hold=%0d last=%0d",
						got.rs, got.nibble, got.enable, got.hold, got.last);
				return;
			end
			want = pending_phases.pop_front();
			if (got !== want) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display({"ERROR: phase expected rs=%0d nib=%h en=%0d hold=%0d last=%0d,",
						" got rs=%0d nib=%h en=%0d hold=%0d last=%0d"},
						want.rs, want.nibble, want.enable, want.hold, want.last,
						got.rs, got.nibble, got.enable, got.hold, got.last);
			end
		endfunction
	endclass

endpackage

>>> verif/char_lcd_4bit_sequencer_test.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit sequencer testbench
// Sends init, command, data and set-cursor requests under several timing
// settings with bursty input and a stalling output, and checks every pin
// phase against the predicted sequence.
// ----------------------------------------------------------------------------
module char_lcd_4bit_sequencer_test;

	import clcd_pkg::*;
	import char_lcd_4bit_sequencer_tb_pkg::*;

	localparam logic [1:0] CFG_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT  = 1000000;
	localparam int         RANDOM_SETS  = 6;
	localparam int         SET_REQUESTS = 70;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;

	pin_phase_tracker board;
	int burst_left;
	int max_gap;
	int ready_mode;
	int stall_left;
	int cycles;

	char_lcd_4bit_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.compare_phase(m_tdata, m_tlast);
	end

	// output stall pattern
	always @(negedge clk) begin
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: begin
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 5) == 0)
						stall_left = $urandom_range(1, 12);
				end
			end
		endcase
	end

	task automatic send_request(kind_t kind, logic [7:0] value, logic [7:0] row,
			logic [7:0] column);
		int gap;
		if (burst_left == 0) begin
			gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {column, row, value};
		do
			@(posedge clk);
		while (!s_tready);
		board.add_request(kind, value, row, column);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_config(logic [7:0] power_up, logic [7:0] pulse, logic [7:0] settle,
			bit stray);
		logic [7:0] regs[3];
		regs = '{power_up, pulse, settle};
		if (stray) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_UNUSED;
			cfg_data <= 8'($urandom);
			board.set_reg(CFG_UNUSED, 8'hA5);
			@(negedge clk);
		end
		for (int i = 0; i < 3; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= regs[i];
			board.set_reg(2'(i), regs[i]);
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] pick_timing();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(0, 8));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_random();
		kind_t kind;
		logic [7:0] row;
		logic [7:0] column;
		kind = ($urandom_range(0, 19) == 0) ? KIND_INIT : kind_t'($urandom_range(1, 3));
		case ($urandom_range(0, 3))
			0, 1: begin
				row = 8'($urandom_range(0, 3));
				column = 8'($urandom_range(0, 19));
			end
			2: begin
				row = 8'($urandom_range(2, 5));
				column = 8'($urandom_range(17, 22));
			end
			default: begin
				row = 8'($urandom);
				column = 8'($urandom);
			end
		endcase
		send_request(kind, 8'($urandom), row, column);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_INIT;
		m_tready = 1'b0;
		burst_left = 0;
		max_gap = 0;
		ready_mode = 0;
		stall_left = 0;
		cycles = 0;
		board = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset timing
		send_request(KIND_INIT, 8'h00, 8'h00, 8'h00);
		send_request(KIND_CMD, 8'h00, 8'h00, 8'h00);
		send_request(KIND_CMD, 8'hFF, 8'hFF, 8'hFF);
		send_request(KIND_DATA, 8'h00, 8'h00, 8'h00);
		send_request(KIND_DATA, 8'hFF, 8'h00, 8'h00);
		send_request(KIND_DATA, 8'hA5, 8'h00, 8'h00);
		send_request(KIND_CURSOR, 8'h00, 8'd0, 8'd0);
		send_request(KIND_CURSOR, 8'h00, 8'd3, 8'd19);
		send_request(KIND_CURSOR, 8'hFF, 8'd255, 8'd255);
		send_request(KIND_CURSOR, 8'h00, 8'd4, 8'd20);
		send_request(KIND_CURSOR, 8'h00, 8'd1, 8'd7);
		send_request(KIND_CURSOR, 8'h00, 8'd2, 8'd0);
		send_request(KIND_CURSOR, 8'h00, 8'd0, 8'd19);
		send_request(KIND_CMD, 8'h5A, 8'h00, 8'h00);
		wait_idle();

		// all timing zero, stray index write ignored
		apply_config(8'd0, 8'd0, 8'd0, 1'b1);
		send_request(KIND_INIT, 8'h00, 8'h00, 8'h00);
		send_request(KIND_CMD, 8'h80, 8'h00, 8'h00);
		send_request(KIND_DATA, 8'h7F, 8'h00, 8'h00);
		send_request(KIND_CURSOR, 8'h00, 8'd3, 8'd0);
		wait_idle();

		// all timing at maximum
		apply_config(8'd255, 8'd255, 8'd255, 1'b0);
		send_request(KIND_INIT, 8'h00, 8'h00, 8'h00);
		send_request(KIND_CMD, 8'h01, 8'h00, 8'h00);
		send_request(KIND_DATA, 8'hFF, 8'h00, 8'h00);
		send_request(KIND_CURSOR, 8'h00, 8'd2, 8'd19);
		wait_idle();

		for (int set = 0; set < RANDOM_SETS; set++) begin
			apply_config(pick_timing(), pick_timing(), pick_timing(), set[0]);
			ready_mode = set % 3;
			max_gap = (set == 0) ? 0 : $urandom_range(1, 8);
			for (int n = 0; n < SET_REQUESTS; n++)
				send_random();
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (board.mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> char_lcd_4bit_sequencer.f
+incdir+hdl
hdl/clcd_pkg.sv
hdl/clcd_front.sv
hdl/clcd_queue.sv
hdl/clcd_back.sv
hdl/char_lcd_4bit_sequencer.sv
hdl/clcd_checker.sv
verif/char_lcd_4bit_sequencer_tb_pkg.sv
verif/char_lcd_4bit_sequencer_test.sv
